### src/svng_pkg.sv
package svng_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_INDEX = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Normalized vertex normal, NORMAL_FRAC_BITS fraction bits
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } norm_res_t;

  localparam int PosW = 16;

endpackage

### src/strip_vertex_normal_generator_top.sv
// Smooth vertex normals for an indexed triangle strip. Op 3 starts a mesh, op 0 appends a
// vertex, op 1 feeds a strip index and op 2 reads a vertex back with its normal
// scaled to unit length in NORMAL_FRAC_BITS fraction bits; only op 2 returns an item. Ops 0
// and 3, and op 1 before the strip holds two indices, complete without leaving the idle state.
// An op 1 that closes a face runs three reads of the position memory, the cross product (two
// multipliers) and three read-modify-writes of the sum memory, forwarded when a face repeats
// a vertex. An in-range op 2 goes through the bit-serial square root and divider of the
// normalizer and may then wait for the result register to empty; an out-of-range read returns
// zeros and status 1. The status bit is sticky per mesh and flags out-of-range indices and
// vertex store overflow.
module strip_vertex_normal_generator_top #(
  parameter int MAX_VERTICES     = 4096,
  parameter int SUM_WIDTH        = 48,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic signed [15:0] pos_w_i,
  input  logic [15:0]        vertex_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [15:0] out_z_o,
  output logic signed [15:0] out_w_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic               status_o
);
  import svng_pkg::*;

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int SW  = SUM_WIDTH;
  localparam int NXW = 35;
  localparam logic signed [SW:0] SMAX = {2'b00, {(SW-1){1'b1}}};
  localparam logic signed [SW:0] SMIN = {2'b11, {(SW-1){1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RDPOS = 9'b000000010,
    S_EDGE  = 9'b000000100,
    S_CROSS = 9'b000001000,
    S_NEG   = 9'b000010000,
    S_RMW   = 9'b000100000,
    S_READ  = 9'b001000000,
    S_NORM  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e            state_q;
  logic [1:0]        cnt_q;
  logic [CW-1:0]     count_q;
  logic [AW-1:0]     older_q, newer_q;
  logic [1:0]        seen_q;
  logic              err_q;
  logic [AW-1:0]     fa0_q, fa1_q, fa2_q;
  logic signed [15:0] px_q [3];
  logic signed [15:0] py_q [3];
  logic signed [15:0] pz_q [3];
  logic signed [16:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [33:0] pa_q, pb_q;
  logic signed [NXW-1:0] n_q [3];
  logic [63:0]       rd_pos_q;
  logic              rd_bad_q;
  logic              fwd_v_q;
  logic [AW-1:0]     fwd_addr_q;
  logic [3*SW-1:0]   fwd_data_q;

  logic              out_valid_q;
  logic signed [15:0] out_x_q, out_y_q, out_z_q, out_w_q;
  logic signed [15:0] nrm_x_q, nrm_y_q, nrm_z_q;
  logic              status_q;

  logic              acc;
  logic              idx_ok;
  logic [AW-1:0]     idx_a;
  logic              pos_we;
  logic [AW-1:0]     pos_raddr;
  logic [63:0]       pos_rdata;
  logic              sum_we;
  logic [AW-1:0]     sum_waddr, sum_raddr;
  logic [3*SW-1:0]   sum_wdata, sum_rdata, sum_old, sum_new;
  logic [AW-1:0]     fa_cur;
  logic signed [16:0] ma, mb, mc, md;
  logic              norm_start, norm_done;
  norm_res_t         norm_res;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign idx_ok     = 17'(vertex_index_i) < 17'(count_q);
  assign idx_a      = vertex_index_i[AW-1:0];

  always_comb begin
    case (cnt_q)
      2'd0:    fa_cur = fa0_q;
      2'd1:    fa_cur = fa1_q;
      default: fa_cur = fa2_q;
    endcase
  end

  // position memory
  assign pos_we = acc && (op_e'(op_i) == OP_LOAD) && (count_q < CW'(MAX_VERTICES));

  always_comb begin
    if (state_q == S_RDPOS) begin
      pos_raddr = (cnt_q == 2'd0) ? fa1_q : fa2_q;
    end else if (op_e'(op_i) == OP_INDEX) begin
      pos_raddr = older_q;
    end else begin
      pos_raddr = idx_a;
    end
  end

  svng_ram #(.WIDTH(64), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({pos_w_i, pos_z_i, pos_y_i, pos_x_i}),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  // saturating accumulate of the face normal, forwarding the previous write
  always_comb begin
    logic signed [SW:0] a, s;
    a = '0;
    s = '0;
    sum_old = (fwd_v_q && (fwd_addr_q == fa_cur)) ? fwd_data_q : sum_rdata;
    for (int k = 0; k < 3; k++) begin
      a = (SW+1)'($signed(sum_old[k*SW +: SW]));
      s = a + (SW+1)'(n_q[k]);
      if (s > SMAX) begin
        s = SMAX;
      end else if (s < SMIN) begin
        s = SMIN;
      end
      sum_new[k*SW +: SW] = s[SW-1:0];
    end
  end

  always_comb begin
    if (state_q == S_RMW) begin
      sum_we    = 1'b1;
      sum_waddr = fa_cur;
      sum_wdata = sum_new;
    end else begin
      sum_we    = pos_we;
      sum_waddr = count_q[AW-1:0];
      sum_wdata = '0;
    end
    case (state_q)
      S_NEG:   sum_raddr = fa0_q;
      S_RMW:   sum_raddr = (cnt_q == 2'd0) ? fa1_q : fa2_q;
      default: sum_raddr = idx_a;
    endcase
  end

  svng_ram #(.WIDTH(3*SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  // cross product operands, one component per cycle
  always_comb begin
    case (cnt_q)
      2'd0:    begin ma = e1y_q; mb = e2z_q; mc = e1z_q; md = e2y_q; end
      2'd1:    begin ma = e1z_q; mb = e2x_q; mc = e1x_q; md = e2z_q; end
      default: begin ma = e1x_q; mb = e2y_q; mc = e1y_q; md = e2x_q; end
    endcase
  end

  assign norm_start = (state_q == S_READ);

  svng_norm #(.SUM_WIDTH(SW), .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .sum_x_i (sum_rdata[SW-1:0]),
    .sum_y_i (sum_rdata[2*SW-1:SW]),
    .sum_z_i (sum_rdata[3*SW-1:2*SW]),
    .done_o  (norm_done),
    .res_o   (norm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      older_q     <= '0;
      newer_q     <= '0;
      seen_q      <= '0;
      err_q       <= 1'b0;
      fwd_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fwd_v_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            case (op_e'(op_i))
              OP_LOAD: begin
                if (count_q < CW'(MAX_VERTICES)) begin
                  count_q <= count_q + 1'b1;
                end else begin
                  err_q <= 1'b1;
                end
              end
              OP_INDEX: begin
                if (!idx_ok) begin
                  err_q <= 1'b1;
                end else begin
                  older_q <= newer_q;
                  newer_q <= idx_a;
                  if (seen_q < 2'd2) begin
                    seen_q <= seen_q + 2'd1;
                  end else begin
                    fa0_q   <= older_q;
                    fa1_q   <= newer_q;
                    fa2_q   <= idx_a;
                    cnt_q   <= 2'd0;
                    state_q <= S_RDPOS;
                  end
                end
              end
              OP_READ: begin
                rd_bad_q <= !idx_ok;
                if (!idx_ok) begin
                  err_q   <= 1'b1;
                  state_q <= S_OUT;
                end else begin
                  state_q <= S_READ;
                end
              end
              default: begin
                count_q <= '0;
                older_q <= '0;
                newer_q <= '0;
                seen_q  <= '0;
                err_q   <= 1'b0;
              end
            endcase
          end
        end
        S_RDPOS: begin
          case (cnt_q)
            2'd0: begin
              px_q[0] <= pos_rdata[15:0];
              py_q[0] <= pos_rdata[31:16];
              pz_q[0] <= pos_rdata[47:32];
            end
            2'd1: begin
              px_q[1] <= pos_rdata[15:0];
              py_q[1] <= pos_rdata[31:16];
              pz_q[1] <= pos_rdata[47:32];
            end
            default: begin
              px_q[2] <= pos_rdata[15:0];
              py_q[2] <= pos_rdata[31:16];
              pz_q[2] <= pos_rdata[47:32];
            end
          endcase
          if (cnt_q == 2'd2) begin
            state_q <= S_EDGE;
            cnt_q   <= 2'd0;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        S_EDGE: begin
          e1x_q   <= 17'(px_q[1]) - 17'(px_q[0]);
          e1y_q   <= 17'(py_q[1]) - 17'(py_q[0]);
          e1z_q   <= 17'(pz_q[1]) - 17'(pz_q[0]);
          e2x_q   <= 17'(px_q[2]) - 17'(px_q[1]);
          e2y_q   <= 17'(py_q[2]) - 17'(py_q[1]);
          e2z_q   <= 17'(pz_q[2]) - 17'(pz_q[1]);
          state_q <= S_CROSS;
        end
        S_CROSS: begin
          pa_q <= ma * mb;
          pb_q <= mc * md;
          case (cnt_q)
            2'd1:    n_q[0] <= NXW'(pa_q) - NXW'(pb_q);
            2'd2:    n_q[1] <= NXW'(pa_q) - NXW'(pb_q);
            2'd3:    n_q[2] <= NXW'(pa_q) - NXW'(pb_q);
            default: ;
          endcase
          if (cnt_q == 2'd3) begin
            state_q <= S_NEG;
            cnt_q   <= 2'd0;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        S_NEG: begin
          // orient every face normal upward
          if (n_q[1] < 0) begin
            n_q[0] <= -n_q[0];
            n_q[1] <= -n_q[1];
            n_q[2] <= -n_q[2];
          end
          state_q <= S_RMW;
          cnt_q   <= 2'd0;
        end
        S_RMW: begin
          fwd_v_q    <= 1'b1;
          fwd_addr_q <= fa_cur;
          fwd_data_q <= sum_new;
          if (cnt_q == 2'd2) begin
            state_q <= S_IDLE;
            cnt_q   <= 2'd0;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        S_READ: begin
          rd_pos_q <= pos_rdata;
          state_q  <= S_NORM;
        end
        S_NORM: begin
          if (norm_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && (!out_valid_q || out_ready_i)) begin
      status_q <= err_q;
      if (rd_bad_q) begin
        out_x_q <= '0;
        out_y_q <= '0;
        out_z_q <= '0;
        out_w_q <= '0;
        nrm_x_q <= '0;
        nrm_y_q <= '0;
        nrm_z_q <= '0;
      end else begin
        out_x_q <= rd_pos_q[15:0];
        out_y_q <= rd_pos_q[31:16];
        out_z_q <= rd_pos_q[47:32];
        out_w_q <= rd_pos_q[63:48];
        nrm_x_q <= norm_res.x;
        nrm_y_q <= norm_res.y;
        nrm_z_q <= norm_res.z;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign out_w_o     = out_w_q;
  assign norm_x_o    = nrm_x_q;
  assign norm_y_o    = nrm_y_q;
  assign norm_z_o    = nrm_z_q;
  assign status_o    = status_q;

  a_err_clear_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(err_q) |-> $past(acc && (op_e'(op_i) == OP_CLEAR)))
    else $error("error flag cleared without a new mesh");

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output state");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_VERTICES))
    else $error("vertex count beyond store size");

  a_rmw_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RMW) |-> (17'(fa_cur) < 17'(count_q)))
    else $error("sum update of a vertex not loaded");

endmodule

### src/svng_ram.sv
module svng_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### src/svng_norm.sv
module svng_norm #(
  parameter int SUM_WIDTH        = 48,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [SUM_WIDTH-1:0] sum_x_i,
  input  logic signed [SUM_WIDTH-1:0] sum_y_i,
  input  logic signed [SUM_WIDTH-1:0] sum_z_i,
  output logic                        done_o,
  output svng_pkg::norm_res_t         res_o
);
  import svng_pkg::*;

  localparam int MW   = SUM_WIDTH;
  localparam int NW   = 32 + NORMAL_FRAC_BITS;
  localparam int CNTW = $clog2(NW);

  typedef enum logic [4:0] {
    N_IDLE  = 5'b00001,
    N_SHIFT = 5'b00010,
    N_SQ    = 5'b00100,
    N_ROOT  = 5'b01000,
    N_DIV   = 5'b10000
  } nstate_e;

  nstate_e          state_q;
  logic [MW-1:0]    m0_q, m1_q, m2_q;
  logic [2:0]       sg_q;
  logic [CNTW-1:0]  cnt_q;
  logic [1:0]       comp_q;
  logic [63:0]      rn_q, r_q, bit_q;
  logic [31:0]      len_q, rem_q;
  logic [NW-1:0]    num_q, quo_q;
  logic             done_q;
  norm_res_t        res_q;

  logic [MW-1:0]    m0_s, m1_s, m2_s, msel;
  logic [61:0]      prod;
  logic [63:0]      rt;
  logic [63:0]      rn_n, r_n;
  logic [32:0]      trial;
  logic             qbit;
  logic [31:0]      rem_n;
  logic [NW-1:0]    quo_n;
  logic [15:0]      sat_val;
  logic             sg_sel;
  logic [30:0]      mnext;

  assign m0_s = sum_x_i[MW-1] ? MW'(-sum_x_i) : MW'(sum_x_i);
  assign m1_s = sum_y_i[MW-1] ? MW'(-sum_y_i) : MW'(sum_y_i);
  assign m2_s = sum_z_i[MW-1] ? MW'(-sum_z_i) : MW'(sum_z_i);

  always_comb begin
    case (comp_q)
      2'd0:    begin msel = m0_q; sg_sel = sg_q[0]; end
      2'd1:    begin msel = m1_q; sg_sel = sg_q[1]; end
      default: begin msel = m2_q; sg_sel = sg_q[2]; end
    endcase
    case (comp_q)
      2'd0:    mnext = m1_q[30:0];
      default: mnext = m2_q[30:0];
    endcase
  end

  assign prod = msel[30:0] * msel[30:0];

  // one step of the bit-serial square root
  always_comb begin
    rt = r_q + bit_q;
    if (rn_q >= rt) begin
      rn_n = rn_q - rt;
      r_n  = (r_q >> 1) + bit_q;
    end else begin
      rn_n = rn_q;
      r_n  = r_q >> 1;
    end
  end

  // one step of the restoring divider
  always_comb begin
    trial = {rem_q, num_q[NW-1]};
    qbit  = (trial >= {1'b0, len_q});
    rem_n = qbit ? 32'(trial - {1'b0, len_q}) : trial[31:0];
    quo_n = {quo_q[NW-2:0], qbit};
    if (sg_sel) begin
      sat_val = (quo_n > NW'(32768)) ? 16'h8000 : 16'(~quo_n[15:0] + 16'd1);
    end else begin
      sat_val = (quo_n > NW'(32767)) ? 16'h7fff : quo_n[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      comp_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        N_IDLE: begin
          if (start_i) begin
            m0_q <= m0_s;
            m1_q <= m1_s;
            m2_q <= m2_s;
            sg_q <= {sum_z_i[MW-1], sum_y_i[MW-1], sum_x_i[MW-1]};
            if ((m0_s | m1_s | m2_s) == '0) begin
              res_q  <= '0;
              done_q <= 1'b1;
            end else begin
              state_q <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          // scale down until the largest magnitude is below 2^31
          if ((m0_q[MW-1:31] | m1_q[MW-1:31] | m2_q[MW-1:31]) != '0) begin
            m0_q <= m0_q >> 1;
            m1_q <= m1_q >> 1;
            m2_q <= m2_q >> 1;
          end else begin
            state_q <= N_SQ;
            comp_q  <= 2'd0;
            rn_q    <= '0;
          end
        end
        N_SQ: begin
          rn_q <= rn_q + 64'(prod);
          if (comp_q == 2'd2) begin
            state_q <= N_ROOT;
            r_q     <= '0;
            bit_q   <= 64'd1 << 62;
            cnt_q   <= '0;
            comp_q  <= 2'd0;
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        N_ROOT: begin
          rn_q  <= rn_n;
          r_q   <= r_n;
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(31)) begin
            state_q <= N_DIV;
            len_q   <= r_n[31:0];
            num_q   <= (NW'(m0_q[30:0]) << NORMAL_FRAC_BITS) + NW'(r_n[31:1]);
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= '0;
          end
        end
        N_DIV: begin
          rem_q <= rem_n;
          quo_q <= quo_n;
          num_q <= num_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(NW-1)) begin
            case (comp_q)
              2'd0:    res_q.x <= sat_val;
              2'd1:    res_q.y <= sat_val;
              default: res_q.z <= sat_val;
            endcase
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= '0;
            num_q <= (NW'(mnext) << NORMAL_FRAC_BITS) + NW'(len_q[31:1]);
            if (comp_q == 2'd2) begin
              done_q  <= 1'b1;
              state_q <= N_IDLE;
              comp_q  <= 2'd0;
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
